>>> rtl/core/ort_pkg.sv
// Types, codes and helpers shared by the ordered record table.
package ort_pkg;

	localparam logic [2:0] ACT_INSERT  = 3'd0;
	localparam logic [2:0] ACT_DELETE  = 3'd1;
	localparam logic [2:0] ACT_READ    = 3'd2;
	localparam logic [2:0] ACT_SEARCH  = 3'd3;
	localparam logic [2:0] ACT_REVERSE = 3'd4;

	localparam logic [2:0] STATUS_OK       = 3'd0;
	localparam logic [2:0] STATUS_FULL     = 3'd1;
	localparam logic [2:0] STATUS_BADPOS   = 3'd2;
	localparam logic [2:0] STATUS_EMPTY    = 3'd3;
	localparam logic [2:0] STATUS_NOTFOUND = 3'd4;

	typedef struct packed {
		logic [2:0]         action;
		logic [6:0]         position;
		logic [55:0]        name_text;
		logic [2:0]         name_len;
		logic signed [31:0] money_in;
	} cmd_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [5:0]         found_index;
		logic [55:0]        out_name_text;
		logic [2:0]         out_name_len;
		logic signed [31:0] out_money;
		logic [6:0]         entry_count;
	} rsp_t;

	typedef struct packed {
		logic [55:0]        name_text;
		logic [2:0]         name_len;
		logic signed [31:0] money;
	} rec_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INS,
		ST_DEL,
		ST_READ,
		ST_SEARCH,
		ST_REV_RA,
		ST_REV_RB,
		ST_REV_WA,
		ST_REV_WB
	} state_t;

	function automatic logic [55:0] name_mask(input logic [2:0] len);
		logic [55:0] m;
		m = '0;
		for (int i = 0; i < 7; i++) begin
			m[i*8 +: 8] = (3'(i) < len) ? 8'hFF : 8'h00;
		end
		return m;
	endfunction

endpackage

>>> rtl/core/ordered_record_table_core.sv
// Ordered record table: insert, delete, read, search and reverse over one record memory.
//
// Usage: drive cmd and raise start while busy is low; the item is taken at that
// clock edge. Exactly one result follows on rsp, marked by a one-cycle done strobe.
// The receiver cannot stall the block; every result must be taken when shown.
// All records live in one memory with one read and one write port and a
// registered read, so every walk is bounded by that port pair.
// Steps from accept to done (n = entries held, p = position):
//   rejected items and unused actions: answered from idle, busy stays low
//   read: one memory read, then the result
//   insert: a direct write when appending, else each entry from n - 1 down to p
//           moves up one place (one move per cycle), then drain and final write
//   delete: no moves for the last entry, else each entry after p moves down one place
//   search: scan from index 0 to the first match; NOTFOUND when none (or table empty)
//   reverse: n/2 pairs, ends inward: read both records, write them back crossed
// busy stays high while a walk runs, until the cycle before done; a new item may be
// started in the cycle done is shown. Reset empties the table (count zero);
// record contents are not cleared and are read only after being written.
module ordered_record_table_core #(
	parameter int DEPTH = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  ort_pkg::cmd_t cmd,
	output logic          busy,
	output logic          done,
	output ort_pkg::rsp_t rsp
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (CW > 7) ? CW : 7;

	ort_pkg::rec_t rec_mem [DEPTH];
	ort_pkg::rec_t rd_data_q;

	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	ort_pkg::rec_t wr_data;

	ort_pkg::state_t state_q, state_d;
	logic [CW-1:0]   count_q, count_d;
	logic [CW-1:0]   idx_q, idx_d;
	logic [AW-1:0]   lo_q, lo_d;
	logic [AW-1:0]   hi_q, hi_d;
	logic [AW-1:0]   pos_q, pos_d;
	ort_pkg::cmd_t   cmd_q, cmd_d;
	logic            pend_s1, pend_d;
	logic [AW-1:0]   pend_addr_s1, pend_addr_d;
	ort_pkg::rec_t   hold_q, hold_d;
	logic            done_q, done_d;
	ort_pkg::rsp_t   rsp_q, rsp_d;

	logic [PW-1:0] pos_w;
	logic [PW-1:0] cnt_w;
	logic [CW-1:0] idx_inc;
	logic [CW-1:0] idx_dec;
	logic [CW-1:0] cnt_dec;
	ort_pkg::rec_t new_rec;

	assign pos_w   = PW'(cmd.position);
	assign cnt_w   = PW'(count_q);
	assign idx_inc = idx_q + CW'(1);
	assign idx_dec = idx_q - CW'(1);
	assign cnt_dec = count_q - CW'(1);

	always_comb begin
		new_rec.name_text = cmd_q.name_text;
		new_rec.name_len  = cmd_q.name_len;
		new_rec.money     = cmd_q.money_in;
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= rec_mem[rd_addr];
		end
		if (wr_en) begin
			rec_mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ort_pkg::ST_IDLE;
			count_q <= '0;
			pend_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			pend_s1 <= pend_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q        <= idx_d;
		lo_q         <= lo_d;
		hi_q         <= hi_d;
		pos_q        <= pos_d;
		cmd_q        <= cmd_d;
		pend_addr_s1 <= pend_addr_d;
		hold_q       <= hold_d;
		rsp_q        <= rsp_d;
	end

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		idx_d       = idx_q;
		lo_d        = lo_q;
		hi_d        = hi_q;
		pos_d       = pos_q;
		cmd_d       = cmd_q;
		pend_d      = 1'b0;
		pend_addr_d = pend_addr_s1;
		hold_d      = hold_q;
		done_d      = 1'b0;
		rsp_d       = rsp_q;
		rd_en       = 1'b0;
		rd_addr     = '0;
		wr_en       = 1'b0;
		wr_addr     = '0;
		wr_data     = rd_data_q;

		unique case (state_q)
			ort_pkg::ST_IDLE: begin
				if (start) begin
					cmd_d           = cmd;
					cmd_d.name_text = cmd.name_text & ort_pkg::name_mask(cmd.name_len);
					pos_d           = pos_w[AW-1:0];
					unique case (cmd.action)
						ort_pkg::ACT_INSERT: begin
							if (count_q >= CW'(DEPTH)) begin
								done_d       = 1'b1;
								rsp_d        = '0;
								rsp_d.status = ort_pkg::STATUS_FULL;
							end else if (pos_w > cnt_w) begin
								done_d       = 1'b1;
								rsp_d        = '0;
								rsp_d.status = ort_pkg::STATUS_BADPOS;
							end else begin
								idx_d   = count_q;
								state_d = ort_pkg::ST_INS;
							end
						end
						ort_pkg::ACT_DELETE, ort_pkg::ACT_READ: begin
							if (count_q == '0) begin
								done_d       = 1'b1;
								rsp_d        = '0;
								rsp_d.status = ort_pkg::STATUS_EMPTY;
							end else if (pos_w >= cnt_w) begin
								done_d       = 1'b1;
								rsp_d        = '0;
								rsp_d.status = ort_pkg::STATUS_BADPOS;
							end else if (cmd.action == ort_pkg::ACT_DELETE) begin
								idx_d   = CW'(pos_w[AW-1:0]);
								state_d = ort_pkg::ST_DEL;
							end else begin
								rd_en   = 1'b1;
								rd_addr = pos_w[AW-1:0];
								state_d = ort_pkg::ST_READ;
							end
						end
						ort_pkg::ACT_SEARCH: begin
							idx_d   = '0;
							state_d = ort_pkg::ST_SEARCH;
						end
						ort_pkg::ACT_REVERSE: begin
							if (count_q < CW'(2)) begin
								done_d       = 1'b1;
								rsp_d        = '0;
								rsp_d.status = ort_pkg::STATUS_OK;
							end else begin
								lo_d    = '0;
								hi_d    = cnt_dec[AW-1:0];
								state_d = ort_pkg::ST_REV_RA;
							end
						end
						default: begin
							done_d       = 1'b1;
							rsp_d        = '0;
							rsp_d.status = ort_pkg::STATUS_OK;
						end
					endcase
				end
			end
			ort_pkg::ST_INS: begin
				if (pend_s1) begin
					wr_en   = 1'b1;
					wr_addr = pend_addr_s1;
					wr_data = rd_data_q;
				end
				if (idx_q > CW'(pos_q)) begin
					rd_en       = 1'b1;
					rd_addr     = idx_dec[AW-1:0];
					pend_d      = 1'b1;
					pend_addr_d = idx_q[AW-1:0];
					idx_d       = idx_dec;
				end else if (!pend_s1) begin
					wr_en        = 1'b1;
					wr_addr      = pos_q;
					wr_data      = new_rec;
					count_d      = count_q + CW'(1);
					done_d       = 1'b1;
					rsp_d        = '0;
					rsp_d.status = ort_pkg::STATUS_OK;
					state_d      = ort_pkg::ST_IDLE;
				end
			end
			ort_pkg::ST_DEL: begin
				if (pend_s1) begin
					wr_en   = 1'b1;
					wr_addr = pend_addr_s1;
					wr_data = rd_data_q;
				end
				if (idx_inc < count_q) begin
					rd_en       = 1'b1;
					rd_addr     = idx_inc[AW-1:0];
					pend_d      = 1'b1;
					pend_addr_d = idx_q[AW-1:0];
					idx_d       = idx_inc;
				end else if (!pend_s1) begin
					count_d      = cnt_dec;
					done_d       = 1'b1;
					rsp_d        = '0;
					rsp_d.status = ort_pkg::STATUS_OK;
					state_d      = ort_pkg::ST_IDLE;
				end
			end
			ort_pkg::ST_READ: begin
				done_d              = 1'b1;
				rsp_d               = '0;
				rsp_d.status        = ort_pkg::STATUS_OK;
				rsp_d.out_name_text = rd_data_q.name_text;
				rsp_d.out_name_len  = rd_data_q.name_len;
				rsp_d.out_money     = rd_data_q.money;
				state_d             = ort_pkg::ST_IDLE;
			end
			ort_pkg::ST_SEARCH: begin
				if (pend_s1 && rd_data_q.name_len == cmd_q.name_len
						&& rd_data_q.name_text == cmd_q.name_text) begin
					done_d            = 1'b1;
					rsp_d             = '0;
					rsp_d.status      = ort_pkg::STATUS_OK;
					rsp_d.found_index = 6'(pend_addr_s1);
					state_d           = ort_pkg::ST_IDLE;
				end else if (idx_q < count_q) begin
					rd_en       = 1'b1;
					rd_addr     = idx_q[AW-1:0];
					pend_d      = 1'b1;
					pend_addr_d = idx_q[AW-1:0];
					idx_d       = idx_inc;
				end else if (!pend_s1) begin
					done_d       = 1'b1;
					rsp_d        = '0;
					rsp_d.status = ort_pkg::STATUS_NOTFOUND;
					state_d      = ort_pkg::ST_IDLE;
				end
			end
			ort_pkg::ST_REV_RA: begin
				rd_en   = 1'b1;
				rd_addr = lo_q;
				state_d = ort_pkg::ST_REV_RB;
			end
			ort_pkg::ST_REV_RB: begin
				rd_en   = 1'b1;
				rd_addr = hi_q;
				hold_d  = rd_data_q;
				state_d = ort_pkg::ST_REV_WA;
			end
			ort_pkg::ST_REV_WA: begin
				wr_en   = 1'b1;
				wr_addr = lo_q;
				wr_data = rd_data_q;
				state_d = ort_pkg::ST_REV_WB;
			end
			ort_pkg::ST_REV_WB: begin
				wr_en   = 1'b1;
				wr_addr = hi_q;
				wr_data = hold_q;
				lo_d    = lo_q + AW'(1);
				hi_d    = hi_q - AW'(1);
				if (CW'(lo_q) + CW'(2) < CW'(hi_q)) begin
					state_d = ort_pkg::ST_REV_RA;
				end else begin
					done_d       = 1'b1;
					rsp_d        = '0;
					rsp_d.status = ort_pkg::STATUS_OK;
					state_d      = ort_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ort_pkg::ST_IDLE;
			end
		endcase

		if (done_d) begin
			rsp_d.entry_count = 7'(count_d);
		end
	end

	assign busy = (state_q != ort_pkg::ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result shown while a walk is still running");

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CW'(DEPTH))
		else $error("entry count beyond capacity");

	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> (busy || done))
		else $error("accepted item produced neither work nor a result");

	assert property (@(posedge clk) disable iff (!arst_n) wr_en |-> busy)
		else $error("memory written while idle");

endmodule

>>> tb/ort_table_checker.sv
// Checker for the ordered record table: tracks the table, predicts each result and compares it.
module ort_table_checker #(
	parameter int DEPTH = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          busy,
	input  ort_pkg::cmd_t cmd,
	input  logic          done,
	input  ort_pkg::rsp_t rsp,
	output int            errors,
	output int            waiting,
	output int            checked
);

	ort_pkg::rec_t rows [DEPTH];
	int            fill = 0;
	ort_pkg::rsp_t due_rsp [$];
	ort_pkg::rsp_t head;
	int            err_total = 0;
	int            queued = 0;
	int            seen = 0;

	assign errors  = err_total;
	assign waiting = queued;
	assign checked = seen;

	function automatic logic [55:0] text_keep(input logic [2:0] len);
		return (len == 3'd0) ? 56'd0 : ({56{1'b1}} >> (8 * (7 - int'(len))));
	endfunction

	function automatic ort_pkg::rsp_t run_action(input ort_pkg::cmd_t c);
		ort_pkg::rsp_t r;
		ort_pkg::rec_t t;
		int            p;
		logic [55:0]   name;
		p = int'(c.position);
		name = c.name_text & text_keep(c.name_len);
		r = '0;
		r.status = ort_pkg::STATUS_OK;
		case (c.action)
			ort_pkg::ACT_INSERT: begin
				if (fill >= DEPTH) begin
					r.status = ort_pkg::STATUS_FULL;
				end else if (p > fill) begin
					r.status = ort_pkg::STATUS_BADPOS;
				end else begin
					for (int a = fill; a > p; a--) rows[a] = rows[a - 1];
					rows[p].name_text = name;
					rows[p].name_len  = c.name_len;
					rows[p].money     = c.money_in;
					fill++;
				end
			end
			ort_pkg::ACT_DELETE: begin
				if (fill == 0) begin
					r.status = ort_pkg::STATUS_EMPTY;
				end else if (p >= fill) begin
					r.status = ort_pkg::STATUS_BADPOS;
				end else begin
					for (int a = p; a + 1 < fill; a++) rows[a] = rows[a + 1];
					fill--;
				end
			end
			ort_pkg::ACT_READ: begin
				if (fill == 0) begin
					r.status = ort_pkg::STATUS_EMPTY;
				end else if (p >= fill) begin
					r.status = ort_pkg::STATUS_BADPOS;
				end else begin
					r.out_name_text = rows[p].name_text;
					r.out_name_len  = rows[p].name_len;
					r.out_money     = rows[p].money;
				end
			end
			ort_pkg::ACT_SEARCH: begin
				r.status = ort_pkg::STATUS_NOTFOUND;
				for (int a = 0; a < fill; a++) begin
					if (rows[a].name_len == c.name_len && rows[a].name_text == name) begin
						r.status = ort_pkg::STATUS_OK;
						r.found_index = 6'(a);
						break;
					end
				end
			end
			ort_pkg::ACT_REVERSE: begin
				for (int a = 0; a < fill / 2; a++) begin
					t = rows[a];
					rows[a] = rows[fill - 1 - a];
					rows[fill - 1 - a] = t;
				end
			end
			default: begin
			end
		endcase
		r.entry_count = 7'(fill);
		return r;
	endfunction

	function automatic void check_field(input string field, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			err_total++;
			$display("%0t: %s expected %0h, got %0h", $time, field, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill = 0;
			due_rsp.delete();
			queued <= 0;
		end else begin
			if (done) begin
				seen++;
				if (due_rsp.size() == 0) begin
					err_total++;
					$display("%0t: result with nothing expected, got %p", $time, rsp);
				end else begin
					head = due_rsp.pop_front();
					check_field("status", 64'(head.status), 64'(rsp.status));
					check_field("found_index", 64'(head.found_index), 64'(rsp.found_index));
					check_field("out_name_text", 64'(head.out_name_text),
						64'(rsp.out_name_text));
					check_field("out_name_len", 64'(head.out_name_len),
						64'(rsp.out_name_len));
					check_field("out_money", 64'(head.out_money), 64'(rsp.out_money));
					check_field("entry_count", 64'(head.entry_count), 64'(rsp.entry_count));
				end
			end
			if (start && !busy) due_rsp.push_back(run_action(cmd));
			queued <= due_rsp.size();
		end
	end

endmodule

>>> tb/tb_ordered_record_table_core.sv
// Testbench top for the ordered record table: drives items in bursts and gives the verdict.
module tb_ordered_record_table_core;

	localparam int DEPTH        = 64;
	localparam int PHASE_ITEMS  = 120;
	localparam int RANDOM_ITEMS = 1225;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          start = 1'b0;
	ort_pkg::cmd_t cmd = '0;
	logic          busy;
	logic          done;
	ort_pkg::rsp_t rsp;
	int            errors;
	int            waiting;
	int            checked;

	int          fill = 0;
	int          per_action [8] = '{default: 0};
	int          full_hits = 0;
	int          burst_left = 0;
	logic [55:0] pool_text [8];

	ordered_record_table_core #(.DEPTH(DEPTH)) DUT (
		.clk, .arst_n, .start, .cmd, .busy, .done, .rsp
	);

	ort_table_checker #(.DEPTH(DEPTH)) table_chk (
		.clk, .arst_n, .start, .busy, .cmd, .done, .rsp, .errors, .waiting, .checked
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#20_000_000;
		$display("FAILURE");
		$finish;
	end

	function automatic logic [55:0] with_junk(input logic [55:0] text, input logic [2:0] len);
		logic [55:0] keep;
		keep = (len == 3'd0) ? 56'd0 : ({56{1'b1}} >> (8 * (7 - int'(len))));
		return (text & keep) | (56'({$urandom, $urandom}) & ~keep);
	endfunction

	function automatic ort_pkg::cmd_t make_cmd(input logic [2:0] action, input logic [6:0] pos,
			input logic [55:0] text, input logic [2:0] len, input logic signed [31:0] money);
		ort_pkg::cmd_t c;
		c.action    = action;
		c.position  = pos;
		c.name_text = text;
		c.name_len  = len;
		c.money_in  = money;
		return c;
	endfunction

	// phase 0 fills, 2 drains, 1 and 3 mix
	function automatic ort_pkg::cmd_t random_item(input int phase);
		ort_pkg::cmd_t c;
		int            r;
		int            ins_w;
		int            del_w;
		int            slot;
		int            hi;
		ins_w = (phase == 0) ? 75 : (phase == 2) ? 5 : 35;
		del_w = (phase == 0) ? 5 : (phase == 2) ? 70 : 30;
		c.name_len  = 3'($urandom);
		c.name_text = 56'({$urandom, $urandom});
		c.position  = 7'($urandom);
		case ($urandom_range(0, 9))
			0: c.money_in = 32'sh8000_0000;
			1: c.money_in = 32'sh7fff_ffff;
			2: c.money_in = -32'sd1;
			default: c.money_in = $urandom;
		endcase
		r = $urandom_range(0, 99);
		if (r < ins_w) begin
			c.action = ort_pkg::ACT_INSERT;
		end else if (r < ins_w + del_w) begin
			c.action = ort_pkg::ACT_DELETE;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 35) c.action = ort_pkg::ACT_READ;
			else if (r < 75) c.action = ort_pkg::ACT_SEARCH;
			else if (r < 93) c.action = ort_pkg::ACT_REVERSE;
			else c.action = ort_pkg::ACT_REVERSE + 3'($urandom_range(1, 3));
		end
		if (c.action == ort_pkg::ACT_INSERT || c.action == ort_pkg::ACT_SEARCH) begin
			if ($urandom_range(0, 4) != 0) begin
				slot = $urandom_range(0, 7);
				c.name_len  = 3'(slot);
				c.name_text = with_junk(pool_text[slot], 3'(slot));
			end
		end
		hi = (c.action == ort_pkg::ACT_INSERT) ? fill : fill - 1;
		if ((c.action == ort_pkg::ACT_INSERT || c.action == ort_pkg::ACT_DELETE
				|| c.action == ort_pkg::ACT_READ)
				&& hi >= 0 && $urandom_range(0, 99) < 85) begin
			c.position = ($urandom_range(0, 4) == 0) ? 7'(hi) : 7'($urandom_range(0, hi));
		end
		return c;
	endfunction

	task automatic issue(input ort_pkg::cmd_t c);
		cmd   <= c;
		start <= 1'b1;
		per_action[c.action]++;
		if (c.action == ort_pkg::ACT_INSERT) begin
			if (fill == DEPTH) full_hits++;
			else if (int'(c.position) <= fill) fill++;
		end else if (c.action == ort_pkg::ACT_DELETE) begin
			if (fill > 0 && int'(c.position) < fill) fill--;
		end
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic drain_all();
		start <= 1'b0;
		do @(posedge clk); while (waiting != 0);
	endtask

	task automatic pace();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 25);
		end
	endtask

	initial begin
		for (int i = 0; i < 8; i++) pool_text[i] = 56'({$urandom, $urandom});
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(make_cmd(ort_pkg::ACT_READ, 7'd0, '0, 3'd0, 32'sd0));
		issue(make_cmd(ort_pkg::ACT_DELETE, 7'd0, '0, 3'd0, 32'sd0));
		issue(make_cmd(ort_pkg::ACT_SEARCH, 7'd0, pool_text[3], 3'd3, 32'sd0));
		issue(make_cmd(ort_pkg::ACT_REVERSE, 7'd0, '0, 3'd0, 32'sd0));
		issue(make_cmd(ort_pkg::ACT_INSERT, 7'd1, pool_text[2], 3'd2, 32'sd5));
		issue(make_cmd(ort_pkg::ACT_INSERT, 7'd0, {56{1'b1}}, 3'd7, 32'sh7fff_ffff));
		issue(make_cmd(ort_pkg::ACT_INSERT, 7'd1, {56{1'b1}}, 3'd0, 32'sh8000_0000));
		issue(make_cmd(ort_pkg::ACT_INSERT, 7'd0, with_junk(pool_text[3], 3'd3), 3'd3,
			-32'sd1));
		issue(make_cmd(ort_pkg::ACT_INSERT, 7'd127, pool_text[4], 3'd4, 32'sd7));
		issue(make_cmd(ort_pkg::ACT_READ, 7'd0, '0, 3'd0, 32'sd0));
		issue(make_cmd(ort_pkg::ACT_READ, 7'd1, '0, 3'd0, 32'sd0));
		issue(make_cmd(ort_pkg::ACT_READ, 7'd3, '0, 3'd0, 32'sd0));
		issue(make_cmd(ort_pkg::ACT_READ, 7'd127, '1, 3'd7, 32'sd0));
		issue(make_cmd(ort_pkg::ACT_SEARCH, 7'd0, with_junk(pool_text[3], 3'd3), 3'd3,
			32'sd0));
		issue(make_cmd(ort_pkg::ACT_SEARCH, 7'd0, {56{1'b1}}, 3'd0, 32'sd0));
		issue(make_cmd(ort_pkg::ACT_SEARCH, 7'd0, pool_text[5], 3'd5, 32'sd0));
		issue(make_cmd(ort_pkg::ACT_REVERSE, 7'd0, '0, 3'd0, 32'sd0));
		issue(make_cmd(ort_pkg::ACT_READ, 7'd0, '0, 3'd0, 32'sd0));
		issue(make_cmd(ort_pkg::ACT_DELETE, 7'd3, '0, 3'd0, 32'sd0));
		issue(make_cmd(ort_pkg::ACT_DELETE, 7'd127, '0, 3'd0, 32'sd0));
		issue(make_cmd(ort_pkg::ACT_DELETE, 7'd1, '0, 3'd0, 32'sd0));
		issue(make_cmd(ort_pkg::ACT_REVERSE + 3'd1, 7'd127, '1, 3'd7, -32'sd1));
		issue(make_cmd(ort_pkg::ACT_REVERSE + 3'd2, 7'd127, '1, 3'd7, -32'sd1));
		issue(make_cmd(ort_pkg::ACT_REVERSE + 3'd3, 7'd127, '1, 3'd7, -32'sd1));
		drain_all();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i > 0 && i % PHASE_ITEMS == 0) drain_all();
			issue(random_item((i / PHASE_ITEMS) % 4));
			pace();
		end
		drain_all();
		repeat (150) @(posedge clk);

		$display("Covered %0d items: insert %0d, delete %0d, read %0d, search %0d,",
			per_action.sum(), per_action[ort_pkg::ACT_INSERT],
			per_action[ort_pkg::ACT_DELETE], per_action[ort_pkg::ACT_READ],
			per_action[ort_pkg::ACT_SEARCH]);
		$display("  reverse %0d, unused %0d; results checked: %0d, full refusals: %0d, mismatches: %0d",
			per_action[ort_pkg::ACT_REVERSE], per_action[5] + per_action[6] + per_action[7],
			checked, full_hits, errors);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
